>>> hw/rtl/pcrct_pkg.sv
package pcrct_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [31:0]      word_t;
  typedef logic [7:0]       out_idx_t;
  typedef logic [8:0]       out_used_t;

  localparam word_t COUNT_MAX = '1;

  // request codes
  typedef enum logic [1:0] {
    REQ_RECORD = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_COUNTED  = 3'd0,
    ST_NEW      = 3'd1,
    ST_FULL     = 3'd2,
    ST_READ_OK  = 3'd3,
    ST_READ_BAD = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0] req_type;
    word_t      client_addr;
    out_idx_t   read_index;
  } req_t;

  typedef struct packed {
    status_e   status;
    out_idx_t  entry_index;
    word_t     entry_addr;
    word_t     entry_count;
    out_used_t entries_used;
  } res_t;

  // one table entry as held in the ram
  typedef struct packed {
    word_t addr;
    word_t count;
  } entry_t;

endpackage

>>> hw/rtl/per_client_request_counter_table.sv
// Per-client request counter table. Each item on req_i is taken at a clock edge with
// start_i high and busy_o low; exactly one result follows on res_o, marked by done_o for a
// single cycle, and must be taken then since the block cannot be stalled (an item with an
// unknown request type gives no result). A record item scans the used entries one per cycle
// through the single read port of the table ram; on a match it writes back the saturating
// incremented count, on a miss it appends a new entry or, with all 256 entries used, reports
// the table full. A read item fetches its entry through the registered read port; a clear
// or an out-of-range read is answered straight from idle. busy_o is high from the cycle
// after an item is taken until the cycle that shows its result, where it is low again, so
// the next item can be taken at the edge ending that cycle; a clear, an out-of-range read
// or an unknown request never raises busy_o. No clearing pass is needed after reset.
module per_client_request_counter_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  pcrct_pkg::req_t req_i,
  output logic            done_o,
  output pcrct_pkg::res_t res_o
);

  logic              wr_en;
  pcrct_pkg::idx_t   wr_addr;
  pcrct_pkg::entry_t wr_data;
  logic              rd_en;
  pcrct_pkg::idx_t   rd_addr;
  pcrct_pkg::entry_t rd_data;

  // search sequencer with shared compare and increment
  pcrct_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .req_i     (req_i),
    .done_o    (done_o),
    .res_o     (res_o),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  // address and count store
  pcrct_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

>>> hw/rtl/pcrct_ram.sv
module pcrct_ram (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  pcrct_pkg::idx_t   wr_addr_i,
  input  pcrct_pkg::entry_t wr_data_i,
  input  logic              rd_en_i,
  input  pcrct_pkg::idx_t   rd_addr_i,
  output pcrct_pkg::entry_t rd_data_o
);

  pcrct_pkg::entry_t mem_q [pcrct_pkg::TABLE_DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

>>> hw/rtl/pcrct_seq.sv
module pcrct_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  pcrct_pkg::req_t   req_i,
  output logic              done_o,
  output pcrct_pkg::res_t   res_o,
  output logic              wr_en_o,
  output pcrct_pkg::idx_t   wr_addr_o,
  output pcrct_pkg::entry_t wr_data_o,
  output logic              rd_en_o,
  output pcrct_pkg::idx_t   rd_addr_o,
  input  pcrct_pkg::entry_t rd_data_i
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_APPEND = 4'b0100,
    S_READ   = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  pcrct_pkg::word_t      key_q, key_d;
  pcrct_pkg::out_idx_t   ridx_q, ridx_d;
  pcrct_pkg::idx_t       cmp_idx_q, cmp_idx_d;
  pcrct_pkg::cnt_t       used_q, used_d;
  pcrct_pkg::res_t       res_q, res_d;
  logic                  done_q, done_d;

  pcrct_pkg::cnt_t       next_cnt;
  pcrct_pkg::word_t      inc_count;
  logic                  hit;

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // shared compare and saturating increment on the entry just read
  assign hit       = (rd_data_i.addr == key_q);
  assign inc_count = (rd_data_i.count == pcrct_pkg::COUNT_MAX) ? pcrct_pkg::COUNT_MAX
                                                               : rd_data_i.count + 32'd1;
  assign next_cnt  = pcrct_pkg::cnt_t'(cmp_idx_q) + pcrct_pkg::cnt_t'(1);

  // sequencer
  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    ridx_d    = ridx_q;
    cmp_idx_d = cmp_idx_q;
    used_d    = used_q;
    res_d     = res_q;
    done_d    = 1'b0;
    rd_en_o   = 1'b0;
    rd_addr_o = cmp_idx_q;
    wr_en_o   = 1'b0;
    wr_addr_o = cmp_idx_q;
    wr_data_o = '{addr: key_q, count: inc_count};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req_i.req_type)
            pcrct_pkg::REQ_RECORD: begin
              key_d     = req_i.client_addr;
              cmp_idx_d = '0;
              if (used_q == '0) begin
                state_d = S_APPEND;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = '0;
                state_d   = S_SCAN;
              end
            end
            pcrct_pkg::REQ_READ: begin
              ridx_d = req_i.read_index;
              if (32'(req_i.read_index) < 32'(used_q)) begin
                rd_en_o   = 1'b1;
                rd_addr_o = pcrct_pkg::idx_t'(req_i.read_index);
                state_d   = S_READ;
              end else begin
                done_d             = 1'b1;
                res_d.status       = pcrct_pkg::ST_READ_BAD;
                res_d.entry_index  = req_i.read_index;
                res_d.entry_addr   = '0;
                res_d.entry_count  = '0;
                res_d.entries_used = pcrct_pkg::out_used_t'(used_q);
              end
            end
            pcrct_pkg::REQ_CLEAR: begin
              used_d             = '0;
              done_d             = 1'b1;
              res_d.status       = pcrct_pkg::ST_CLEARED;
              res_d.entry_index  = '0;
              res_d.entry_addr   = '0;
              res_d.entry_count  = '0;
              res_d.entries_used = '0;
            end
            default: ;
          endcase
        end
      end

      // one entry compared per cycle while the next one is fetched
      S_SCAN: begin
        if (hit) begin
          wr_en_o            = 1'b1;
          done_d             = 1'b1;
          res_d.status       = pcrct_pkg::ST_COUNTED;
          res_d.entry_index  = pcrct_pkg::out_idx_t'(cmp_idx_q);
          res_d.entry_addr   = key_q;
          res_d.entry_count  = inc_count;
          res_d.entries_used = pcrct_pkg::out_used_t'(used_q);
          state_d            = S_IDLE;
        end else if (next_cnt == used_q) begin
          state_d = S_APPEND;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = pcrct_pkg::idx_t'(next_cnt);
          cmp_idx_d = pcrct_pkg::idx_t'(next_cnt);
        end
      end

      // miss: add a new entry or report the table full
      S_APPEND: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (used_q == pcrct_pkg::cnt_t'(pcrct_pkg::TABLE_DEPTH)) begin
          res_d.status       = pcrct_pkg::ST_FULL;
          res_d.entry_index  = '0;
          res_d.entry_addr   = key_q;
          res_d.entry_count  = '0;
          res_d.entries_used = pcrct_pkg::out_used_t'(used_q);
        end else begin
          wr_en_o            = 1'b1;
          wr_addr_o          = pcrct_pkg::idx_t'(used_q);
          wr_data_o          = '{addr: key_q, count: 32'd1};
          used_d             = used_q + pcrct_pkg::cnt_t'(1);
          res_d.status       = pcrct_pkg::ST_NEW;
          res_d.entry_index  = pcrct_pkg::out_idx_t'(used_q);
          res_d.entry_addr   = key_q;
          res_d.entry_count  = 32'd1;
          res_d.entries_used = pcrct_pkg::out_used_t'(used_q + pcrct_pkg::cnt_t'(1));
        end
      end

      // read data for a valid index has arrived
      S_READ: begin
        done_d             = 1'b1;
        state_d            = S_IDLE;
        res_d.status       = pcrct_pkg::ST_READ_OK;
        res_d.entry_index  = ridx_q;
        res_d.entry_addr   = rd_data_i.addr;
        res_d.entry_count  = rd_data_i.count;
        res_d.entries_used = pcrct_pkg::out_used_t'(used_q);
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    ridx_q    <= ridx_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
  end

  // checks
  a_used_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= pcrct_pkg::TABLE_DEPTH)
    else $error("entry count beyond table depth");

  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result given while sequencer still busy");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.req_type == pcrct_pkg::REQ_CLEAR) |=> used_q == '0)
    else $error("clear left entries in the table");

  a_new_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.status == pcrct_pkg::ST_NEW) |->
      used_q == $past(used_q) + pcrct_pkg::cnt_t'(1))
    else $error("new entry without growth of the table");

  a_write_in_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (state_q == S_SCAN || state_q == S_APPEND))
    else $error("table written outside search or append");

endmodule

>>> dv/request_count_checker.sv
`timescale 1ns / 1ps

// watches the request and result channels of the counter table, keeps its own
// copy of the client table and checks every result against it
module request_count_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  pcrct_pkg::req_t req_i,
  input  logic            done_i,
  input  pcrct_pkg::res_t res_i,
  output int              mismatches_o,
  output int              owed_count_o
);

  // shadow of the client table
  pcrct_pkg::word_t client_tbl [pcrct_pkg::TABLE_DEPTH];
  pcrct_pkg::word_t hits_tbl   [pcrct_pkg::TABLE_DEPTH];
  int unsigned      clients_live;

  // results still to come, oldest first
  pcrct_pkg::res_t owed_results [$];

  // applies one request to the shadow table, returns 0 when no result follows
  function automatic bit tally_request(input pcrct_pkg::req_t r, output pcrct_pkg::res_t o);
    int hit;
    o   = '0;
    hit = -1;
    case (r.req_type)
      pcrct_pkg::REQ_RECORD: begin
        // first matching entry wins
        for (int k = 0; k < clients_live; k++)
          if (hit < 0 && client_tbl[k] == r.client_addr) hit = k;
        if (hit >= 0) begin
          if (hits_tbl[hit] != pcrct_pkg::COUNT_MAX) hits_tbl[hit]++;
          o.status      = pcrct_pkg::ST_COUNTED;
          o.entry_index = hit[7:0];
          o.entry_addr  = client_tbl[hit];
          o.entry_count = hits_tbl[hit];
        end else if (clients_live < pcrct_pkg::TABLE_DEPTH) begin
          client_tbl[clients_live] = r.client_addr;
          hits_tbl[clients_live]   = 32'd1;
          o.status      = pcrct_pkg::ST_NEW;
          o.entry_index = clients_live[7:0];
          o.entry_addr  = r.client_addr;
          o.entry_count = 32'd1;
          clients_live++;
        end else begin
          // table full: request dropped
          o.status     = pcrct_pkg::ST_FULL;
          o.entry_addr = r.client_addr;
        end
      end
      pcrct_pkg::REQ_READ: begin
        o.entry_index = r.read_index;
        if (r.read_index < clients_live) begin
          o.status      = pcrct_pkg::ST_READ_OK;
          o.entry_addr  = client_tbl[r.read_index];
          o.entry_count = hits_tbl[r.read_index];
        end else begin
          o.status = pcrct_pkg::ST_READ_BAD;
        end
      end
      pcrct_pkg::REQ_CLEAR: begin
        clients_live = 0;
        o.status     = pcrct_pkg::ST_CLEARED;
      end
      default: return 1'b0;
    endcase
    o.entries_used = clients_live[8:0];
    return 1'b1;
  endfunction

  // one field compare, returns 1 on a mismatch
  function automatic int field_diff(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // results first, then the item taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    pcrct_pkg::res_t want;
    pcrct_pkg::res_t fresh;
    if (!rst_ni) begin
      clients_live = 0;
      owed_results.delete();
      mismatches_o = 0;
      owed_count_o = 0;
    end else begin
      if (done_i) begin
        if (owed_results.size() == 0) begin
          $error("result with no request waiting: %p", res_i);
          mismatches_o++;
        end else begin
          want = owed_results.pop_front();
          mismatches_o += field_diff("status", 32'(want.status), 32'(res_i.status));
          mismatches_o += field_diff("entry_index", 32'(want.entry_index),
                                     32'(res_i.entry_index));
          mismatches_o += field_diff("entry_addr", want.entry_addr, res_i.entry_addr);
          mismatches_o += field_diff("entry_count", want.entry_count, res_i.entry_count);
          mismatches_o += field_diff("entries_used", 32'(want.entries_used),
                                     32'(res_i.entries_used));
        end
      end
      if (start_i && !busy_i) begin
        if (tally_request(req_i, fresh)) owed_results.push_back(fresh);
      end
      owed_count_o = owed_results.size();
    end
  end

endmodule

>>> dv/tb_per_client_request_counter_table.sv
`timescale 1ns / 1ps

module tb_per_client_request_counter_table;

  // request code the block ignores
  localparam logic [1:0]  REQ_BOGUS   = 2'd3;
  localparam int          ITEM_TARGET = 1350;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          TAIL_CYCLES = 300;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start_i;
  logic            busy_o;
  pcrct_pkg::req_t req_i;
  logic            done_o;
  pcrct_pkg::res_t res_o;

  int          mismatches;
  int          owed_count;
  int          sent;
  bit          idle_on;
  int unsigned cycles = 0;

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  per_client_request_counter_table dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  request_count_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .req_i        (req_i),
    .done_i       (done_o),
    .res_i        (res_o),
    .mismatches_o (mismatches),
    .owed_count_o (owed_count)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // drive one item from a falling edge, return at the falling edge after it is taken
  task automatic issue(input logic [1:0] kind, input pcrct_pkg::word_t addr,
                       input pcrct_pkg::out_idx_t idx);
    pcrct_pkg::req_t r;
    r.req_type    = kind;
    r.client_addr = addr;
    r.read_index  = idx;
    while (idle_on && $urandom_range(0, 99) < 19) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    if (kind != REQ_BOGUS) sent++;
  endtask

  // hold off until every result owed has come back
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (owed_count != 0);
  endtask

  initial begin
    pcrct_pkg::word_t pool [16];
    pcrct_pkg::word_t base;
    int               psz;
    int               nitems;
    int               roll;
    int               ep;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    sent    = 0;
    idle_on = 1'b1;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty reads, address extremes, repeat hits, ignored type, clears
    issue(pcrct_pkg::REQ_READ, 32'h0, 8'd0);
    issue(pcrct_pkg::REQ_READ, 32'hFFFF_FFFF, 8'hFF);
    issue(pcrct_pkg::REQ_RECORD, 32'h0000_0000, 8'h00);
    issue(pcrct_pkg::REQ_RECORD, 32'hFFFF_FFFF, 8'hFF);
    issue(pcrct_pkg::REQ_RECORD, 32'h0000_0000, 8'h00);
    issue(pcrct_pkg::REQ_RECORD, 32'h0000_0000, 8'hFF);
    issue(pcrct_pkg::REQ_READ, 32'h0, 8'd0);
    issue(pcrct_pkg::REQ_READ, 32'hFFFF_FFFF, 8'd1);
    issue(pcrct_pkg::REQ_READ, 32'h0, 8'd2);
    issue(REQ_BOGUS, 32'hFFFF_FFFF, 8'hFF);
    issue(pcrct_pkg::REQ_RECORD, 32'h8000_0000, 8'h00);
    issue(pcrct_pkg::REQ_RECORD, 32'h0000_0001, 8'h00);
    issue(pcrct_pkg::REQ_READ, 32'h0, 8'hFF);
    issue(pcrct_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 8'hFF);
    issue(pcrct_pkg::REQ_READ, 32'h0, 8'd0);
    issue(pcrct_pkg::REQ_RECORD, 32'hFFFF_FFFF, 8'h00);
    issue(pcrct_pkg::REQ_READ, 32'h0, 8'd0);
    issue(pcrct_pkg::REQ_CLEAR, 32'h0, 8'h00);
    issue(pcrct_pkg::REQ_CLEAR, 32'h0, 8'h00);
    drain();

    // random episodes; a saturated count needs 2^32-1 hits and is out of reach here
    ep = 0;
    while (sent < ITEM_TARGET) begin
      idle_on = !(ep inside {1, 2, 3});
      if (ep == 2 || ep == 6) begin
        // fill the whole table, then overflow it
        issue(pcrct_pkg::REQ_CLEAR, $urandom, 8'($urandom));
        base = $urandom;
        for (int i = 0; i < pcrct_pkg::TABLE_DEPTH; i++) begin
          if ($urandom_range(0, 99) < 15)
            issue(pcrct_pkg::REQ_READ, $urandom, 8'($urandom_range(0, i)));
          if (i > 0 && $urandom_range(0, 99) < 10)
            issue(pcrct_pkg::REQ_RECORD, {base[31:8], 8'($urandom_range(0, i - 1))},
                  8'($urandom));
          issue(pcrct_pkg::REQ_RECORD, {base[31:8], 8'(i)}, 8'($urandom));
        end
        repeat (40) begin
          roll = $urandom_range(0, 99);
          if (roll < 40)
            issue(pcrct_pkg::REQ_RECORD, {base[31:8] ^ 24'($urandom_range(1, 24'hFF_FFFF)),
                                          8'($urandom)}, 8'($urandom));
          else if (roll < 70)
            issue(pcrct_pkg::REQ_RECORD, {base[31:8], 8'($urandom)}, 8'($urandom));
          else if (roll < 95) issue(pcrct_pkg::REQ_READ, $urandom, 8'($urandom));
          else issue(REQ_BOGUS, $urandom, 8'($urandom));
        end
      end else begin
        // small pool of clients so most records hit
        psz = $urandom_range(1, 12);
        for (int k = 0; k < psz; k++)
          pool[k] = ($urandom_range(0, 9) == 0) ? '1 : pcrct_pkg::word_t'($urandom);
        if ($urandom_range(0, 99) < 80) issue(pcrct_pkg::REQ_CLEAR, $urandom, 8'($urandom));
        nitems = $urandom_range(20, 60);
        repeat (nitems) begin
          roll = $urandom_range(0, 99);
          if (roll < 55)
            issue(pcrct_pkg::REQ_RECORD, pool[$urandom_range(0, psz - 1)], 8'($urandom));
          else if (roll < 65) issue(pcrct_pkg::REQ_RECORD, $urandom, 8'($urandom));
          else if (roll < 85)
            issue(pcrct_pkg::REQ_READ, $urandom, 8'($urandom_range(0, psz + 4)));
          else if (roll < 93) issue(pcrct_pkg::REQ_READ, $urandom, 8'($urandom));
          else if (roll < 97) issue(pcrct_pkg::REQ_CLEAR, $urandom, 8'($urandom));
          else issue(REQ_BOGUS, $urandom, 8'($urandom));
        end
      end
      drain();
      ep++;
    end

    // let any stray result show up
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && owed_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
